// ===== sv/wwss_pkg.sv =====
// Shared types, constants and register indexes for the wake window sleep scheduler.
package wwss_pkg;

  // Time constants
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned SCAN_DAYS     = 8;

  // Field widths
  localparam int unsigned DAY_W    = 3;
  localparam int unsigned MOD_W    = 11;
  localparam int unsigned NOW_W    = 17;
  localparam int unsigned UPD_W    = 17;
  localparam int unsigned SLEEP_W  = 20;
  localparam int unsigned REASON_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Reason codes
  localparam logic [REASON_W-1:0] REASON_NO_TIME = 2'd0;
  localparam logic [REASON_W-1:0] REASON_INSIDE  = 2'd1;
  localparam logic [REASON_W-1:0] REASON_OUTSIDE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_DAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_INT  = 3'd5;

  // Result source picked by the front end
  typedef enum logic [1:0] {
    SEL_BACKOFF = 2'd0,
    SEL_UPDATE  = 2'd1,
    SEL_DIST    = 2'd2
  } sel_t;

  typedef struct packed {
    logic               time_valid;
    logic [DAY_W-1:0]   weekday;
    logic [4:0]         hour_of_day;
    logic [5:0]         minute_of_hour;
    logic [5:0]         second_of_minute;
  } in_t;

  typedef struct packed {
    logic [SLEEP_W-1:0]  sleep_seconds;
    logic [REASON_W-1:0] reason;
  } out_t;

  typedef struct packed {
    logic [DAY_W-1:0]   first_active_day;
    logic [DAY_W-1:0]   last_active_day;
    logic [MOD_W-1:0]   window_start_minute;
    logic [MOD_W-1:0]   window_end_minute;
    logic [UPD_W-1:0]   update_interval;
    logic [SLEEP_W-1:0] backoff_interval;
  } cfg_t;

  // Classified query handed from front to back
  typedef struct packed {
    sel_t                sel;
    logic [REASON_W-1:0] reason;
    logic [DAY_W-1:0]    days;
    logic [NOW_W-1:0]    now_s;
  } job_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// ===== sv/wwss_front.sv =====
// Front end: accepts a query and classifies it into a job for the back end.
module wwss_front (
  input  logic            start,
  input  wwss_pkg::in_t   in_data,
  input  wwss_pkg::cfg_t  cfg,
  input  wwss_pkg::q_stat_t q_stat,
  output logic            busy,
  output logic            push,
  output wwss_pkg::job_t  job
);

  // Fold a sum of weekday and offset (0..14) into 0..6
  function automatic logic [wwss_pkg::DAY_W-1:0] wrap_day(input logic [3:0] sum);
    logic [wwss_pkg::DAY_W-1:0] res;
    if (sum >= 4'(2 * wwss_pkg::DAYS_PER_WEEK)) begin
      res = '0;
    end else if (sum >= 4'(wwss_pkg::DAYS_PER_WEEK)) begin
      res = 3'(sum - 4'(wwss_pkg::DAYS_PER_WEEK));
    end else begin
      res = 3'(sum);
    end
    return res;
  endfunction

  logic [wwss_pkg::MOD_W-1:0] min_of_day;
  logic [wwss_pkg::NOW_W-1:0] now_s;
  logic [wwss_pkg::NOW_W-1:0] target_s;
  logic                       in_time;
  logic                       today_active;
  logic [wwss_pkg::SCAN_DAYS-1:0] day_act;
  logic                       found;
  logic [wwss_pkg::DAY_W-1:0] days;

  // Accept whenever the queue has room
  assign busy = q_stat.full;
  assign push = start && !busy;

  // Minute and second of day, window start in seconds
  assign min_of_day = 11'(in_data.hour_of_day) * 11'(wwss_pkg::SEC_PER_MIN)
                    + 11'(in_data.minute_of_hour);
  assign now_s = 17'(in_data.hour_of_day) * 17'(wwss_pkg::SEC_PER_HOUR)
               + 17'(in_data.minute_of_hour) * 17'(wwss_pkg::SEC_PER_MIN)
               + 17'(in_data.second_of_minute);
  assign target_s = 17'(cfg.window_start_minute) * 17'(wwss_pkg::SEC_PER_MIN);

  assign in_time = (min_of_day >= cfg.window_start_minute) &&
                   (min_of_day < cfg.window_end_minute);
  assign today_active = (in_data.weekday >= cfg.first_active_day) &&
                        (in_data.weekday <= cfg.last_active_day);

  // Mark active days over the scan span
  always_comb begin
    for (int d = 0; d < int'(wwss_pkg::SCAN_DAYS); d++) begin
      day_act[d] = (wrap_day(4'(in_data.weekday) + 4'(d)) >= cfg.first_active_day) &&
                   (wrap_day(4'(in_data.weekday) + 4'(d)) <= cfg.last_active_day);
    end
  end

  // Pick the nearest window start: today if still ahead, else first later day
  always_comb begin
    found = 1'b0;
    days  = '0;
    for (int d = int'(wwss_pkg::SCAN_DAYS) - 1; d > 0; d--) begin
      if (day_act[d]) begin
        found = 1'b1;
        days  = 3'(d);
      end
    end
    if (day_act[0] && (now_s < target_s)) begin
      found = 1'b1;
      days  = '0;
    end
  end

  // Classify the query
  always_comb begin
    job.days  = days;
    job.now_s = now_s;
    if (!in_data.time_valid) begin
      job.sel    = wwss_pkg::SEL_BACKOFF;
      job.reason = wwss_pkg::REASON_NO_TIME;
    end else if (today_active && in_time) begin
      job.sel    = wwss_pkg::SEL_UPDATE;
      job.reason = wwss_pkg::REASON_INSIDE;
    end else if (found) begin
      job.sel    = wwss_pkg::SEL_DIST;
      job.reason = wwss_pkg::REASON_OUTSIDE;
    end else begin
      job.sel    = wwss_pkg::SEL_BACKOFF;
      job.reason = wwss_pkg::REASON_OUTSIDE;
    end
  end

endmodule

// ===== sv/wwss_queue.sv =====
// Two-entry job queue between the front end and the back end.
module wwss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wwss_pkg::job_t    push_job,
  input  logic              pop,
  output wwss_pkg::job_t    head_job,
  output wwss_pkg::q_stat_t q_stat
);

  wwss_pkg::job_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign q_stat.empty = (count_r == 2'd0);
  assign q_stat.full  = (count_r == 2'd2);
  assign head_job     = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/wwss_back.sv =====
// Back end: turns a queued job into the sleep time and registers the result.
module wwss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wwss_pkg::cfg_t    cfg,
  input  wwss_pkg::q_stat_t q_stat,
  input  wwss_pkg::job_t    job,
  output logic              pop,
  output logic              out_valid,
  output wwss_pkg::out_t    out_data
);

  logic [wwss_pkg::SLEEP_W-1:0] day_sec;
  logic [wwss_pkg::SLEEP_W-1:0] target_s;
  logic [wwss_pkg::SLEEP_W-1:0] pos_s;
  logic [wwss_pkg::SLEEP_W-1:0] now_ext;
  logic [wwss_pkg::SLEEP_W-1:0] dist_s;
  logic [wwss_pkg::SLEEP_W-1:0] upd_ext;
  logic [wwss_pkg::SLEEP_W-1:0] dist_min;
  logic                         out_valid_r;
  wwss_pkg::out_t               out_data_r, out_data_nxt;

  // Drain one job every cycle the queue holds one
  assign pop = !q_stat.empty;

  // Distance to the chosen window start, clamped at zero, raised to the update interval
  assign day_sec  = 20'(job.days) * 20'(wwss_pkg::SEC_PER_DAY);
  assign target_s = 20'(cfg.window_start_minute) * 20'(wwss_pkg::SEC_PER_MIN);
  assign pos_s    = day_sec + target_s;
  assign now_ext  = 20'(job.now_s);
  assign dist_s   = (pos_s > now_ext) ? (pos_s - now_ext) : '0;
  assign upd_ext  = 20'(cfg.update_interval);
  assign dist_min = (dist_s < upd_ext) ? upd_ext : dist_s;

  // Select the result source
  always_comb begin
    out_data_nxt.reason = job.reason;
    unique case (job.sel)
      wwss_pkg::SEL_BACKOFF: out_data_nxt.sleep_seconds = cfg.backoff_interval;
      wwss_pkg::SEL_UPDATE:  out_data_nxt.sleep_seconds = upd_ext;
      wwss_pkg::SEL_DIST:    out_data_nxt.sleep_seconds = dist_min;
      default:               out_data_nxt.sleep_seconds = cfg.backoff_interval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pop;
    end
  end

  // Hold the result payload for its strobe cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/wake_window_sleep_scheduler.sv =====
// Top level of the wake window sleep scheduler: config registers and the front/queue/back chain.
//
//  channel | ports                          | transaction
//  --------+--------------------------------+----------------------------------
//  input   | start, busy, in_data           | start high and busy low at clk
//  result  | out_valid, out_data            | out_valid high for one cycle
//  config  | cfg_we, cfg_index, cfg_wdata   | cfg_we high at clk
//
// One query per cycle. A query accepted at one edge is classified and written into the
// two-entry queue at that edge; the back end pops it in the next cycle and registers
// the result, which strobes in the cycle after the pop.
// The back end drains the queue every cycle, so busy stays low in normal operation.
// The receiver cannot hold results off; each result strobes for exactly one cycle.
// Reset is synchronous, active low; it loads the register defaults and empties the queue.
module wake_window_sleep_scheduler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  wwss_pkg::in_t                       in_data,
  output logic                                out_valid,
  output wwss_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [wwss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wwss_pkg::SLEEP_W-1:0]        cfg_wdata
);

  wwss_pkg::cfg_t    cfg_r, cfg_nxt;
  wwss_pkg::job_t    front_job;
  wwss_pkg::job_t    head_job;
  wwss_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        wwss_pkg::CFG_FIRST_DAY:   cfg_nxt.first_active_day    = cfg_wdata[2:0];
        wwss_pkg::CFG_LAST_DAY:    cfg_nxt.last_active_day     = cfg_wdata[2:0];
        wwss_pkg::CFG_WIN_START:   cfg_nxt.window_start_minute = cfg_wdata[10:0];
        wwss_pkg::CFG_WIN_END:     cfg_nxt.window_end_minute   = cfg_wdata[10:0];
        wwss_pkg::CFG_UPDATE_INT:  cfg_nxt.update_interval     = cfg_wdata[16:0];
        wwss_pkg::CFG_BACKOFF_INT: cfg_nxt.backoff_interval    = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_active_day    <= 3'd1;
      cfg_r.last_active_day     <= 3'd5;
      cfg_r.window_start_minute <= 11'd475;
      cfg_r.window_end_minute   <= 11'd1080;
      cfg_r.update_interval     <= 17'd300;
      cfg_r.backoff_interval    <= 20'd3600;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wwss_front u_front (
    .start   (start),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .busy    (busy),
    .push    (push),
    .job     (front_job)
  );

  wwss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  wwss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .job       (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/wake_window_sleep_scheduler_tb.sv =====
// Testbench for the wake window sleep scheduler: directed table, then randomized queries.
`timescale 1ns / 100ps

module wake_window_sleep_scheduler_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned DRAIN_CYCLES = 4;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct {
    logic        valid;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    bit          typed;
    int unsigned exp_sleep;
    logic [1:0]  exp_reason;
  } query_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  wwss_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  wwss_pkg::out_t                 out_data;
  logic                           cfg_we = 1'b0;
  logic [wwss_pkg::CFG_IDX_W-1:0] cfg_index = wwss_pkg::CFG_FIRST_DAY;
  logic [wwss_pkg::SLEEP_W-1:0]   cfg_wdata = '0;

  // Typed expectation that travels with the query on the bus
  bit             row_typed = 1'b0;
  wwss_pkg::out_t row_result = '0;

  wwss_pkg::cfg_t shadow_cfg;
  wwss_pkg::out_t pending_wakes[$];
  int unsigned    cycle_count = 0;
  int unsigned    error_count = 0;
  int unsigned    idle_pct = 0;

  query_row_t directed_rows [0:15] = '{
    '{1'b0, 3'd0, 5'd0,  6'd0,  6'd0,  1'b1, 3600, wwss_pkg::REASON_NO_TIME},
    '{1'b0, 3'd7, 5'd31, 6'd63, 6'd63, 1'b1, 3600, wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd1, 5'd7,  6'd55, 6'd0,  1'b1, 300,  wwss_pkg::REASON_INSIDE},
    '{1'b1, 3'd5, 5'd17, 6'd59, 6'd59, 1'b1, 300,  wwss_pkg::REASON_INSIDE},
    '{1'b1, 3'd3, 5'd12, 6'd0,  6'd0,  1'b1, 300,  wwss_pkg::REASON_INSIDE},
    '{1'b1, 3'd2, 5'd7,  6'd63, 6'd63, 1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd1, 5'd18, 6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd5, 5'd18, 6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd6, 5'd12, 6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd0, 5'd0,  6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd1, 5'd7,  6'd54, 6'd59, 1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd1, 5'd7,  6'd54, 6'd58, 1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd1, 5'd0,  6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd7, 5'd12, 6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd7, 5'd3,  6'd0,  6'd0,  1'b0, 0,    wwss_pkg::REASON_NO_TIME},
    '{1'b1, 3'd1, 5'd31, 6'd63, 6'd63, 1'b0, 0,    wwss_pkg::REASON_NO_TIME}
  };

  wake_window_sleep_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic wwss_pkg::cfg_t make_cfg(int unsigned first, int unsigned last,
                                              int unsigned win_start, int unsigned win_end,
                                              int unsigned upd, int unsigned backoff);
    wwss_pkg::cfg_t c;
    c.first_active_day    = first[wwss_pkg::DAY_W-1:0];
    c.last_active_day     = last[wwss_pkg::DAY_W-1:0];
    c.window_start_minute = win_start[wwss_pkg::MOD_W-1:0];
    c.window_end_minute   = win_end[wwss_pkg::MOD_W-1:0];
    c.update_interval     = upd[wwss_pkg::UPD_W-1:0];
    c.backoff_interval    = backoff[wwss_pkg::SLEEP_W-1:0];
    return c;
  endfunction

  function automatic bit day_active(int unsigned day, wwss_pkg::cfg_t c);
    return day >= c.first_active_day && day <= c.last_active_day;
  endfunction

  // Compute the sleep length and reason for one query under the given settings
  function automatic wwss_pkg::out_t next_wake(wwss_pkg::in_t q, wwss_pkg::cfg_t c);
    wwss_pkg::out_t r;
    int unsigned    mod_min;
    int unsigned    sleep;
    int             now_s;
    int             target;
    int             days;
    int             gap_s;
    bit             found;
    mod_min = q.hour_of_day * wwss_pkg::SEC_PER_MIN + q.minute_of_hour;
    if (!q.time_valid) begin
      sleep = 32'(c.backoff_interval);
      r.reason = wwss_pkg::REASON_NO_TIME;
    end else if (day_active(32'(q.weekday), c) && mod_min >= c.window_start_minute &&
                 mod_min < c.window_end_minute) begin
      sleep = 32'(c.update_interval);
      r.reason = wwss_pkg::REASON_INSIDE;
    end else begin
      now_s = q.hour_of_day * wwss_pkg::SEC_PER_HOUR +
              q.minute_of_hour * wwss_pkg::SEC_PER_MIN + q.second_of_minute;
      target = c.window_start_minute * wwss_pkg::SEC_PER_MIN;
      found = 1'b0;
      days = 0;
      // Scan today and the next seven days; today only counts before window start
      for (int d = 0; d < wwss_pkg::SCAN_DAYS; d++) begin
        if (!found && day_active((q.weekday + d) % wwss_pkg::DAYS_PER_WEEK, c) &&
            (d > 0 || now_s < target)) begin
          found = 1'b1;
          days = d;
        end
      end
      r.reason = wwss_pkg::REASON_OUTSIDE;
      if (!found) begin
        sleep = 32'(c.backoff_interval);
      end else begin
        gap_s = days * wwss_pkg::SEC_PER_DAY - now_s + target;
        if (gap_s < 0) gap_s = 0;
        sleep = gap_s;
        if (sleep < c.update_interval) sleep = 32'(c.update_interval);
      end
    end
    r.sleep_seconds = sleep[wwss_pkg::SLEEP_W-1:0];
    return r;
  endfunction

  // Random query: mostly valid and in range, often near a window edge
  function automatic wwss_pkg::in_t rand_query(wwss_pkg::cfg_t c);
    wwss_pkg::in_t q;
    int unsigned   pick;
    int            m;
    q.time_valid = ($urandom_range(9) != 0);
    q.weekday = ($urandom_range(15) == 0) ? 3'd7 : 3'($urandom_range(6));
    pick = $urandom_range(9);
    if (pick == 0) begin
      q.hour_of_day      = 5'($urandom_range(31));
      q.minute_of_hour   = 6'($urandom_range(63));
      q.second_of_minute = 6'($urandom_range(63));
    end else if (pick <= 3) begin
      m = ($urandom_range(1) ? int'(c.window_start_minute) : int'(c.window_end_minute)) +
          int'($urandom_range(4)) - 2;
      if (m < 0) m = 0;
      if (m > 1439) m = 1439;
      q.hour_of_day      = 5'(m / 60);
      q.minute_of_hour   = 6'(m % 60);
      q.second_of_minute = 6'($urandom_range(59));
    end else begin
      q.hour_of_day      = 5'($urandom_range(23));
      q.minute_of_hour   = 6'($urandom_range(59));
      q.second_of_minute = 6'($urandom_range(59));
    end
    return q;
  endfunction

  function automatic wwss_pkg::cfg_t rand_cfg();
    int unsigned upd;
    upd = $urandom_range(1) ? $urandom_range(600, 1) : $urandom_range(86400, 1);
    return make_cfg($urandom_range(6), $urandom_range(6), $urandom_range(1439),
                    $urandom_range(1440), upd, $urandom_range(604800, 1));
  endfunction

  // Present one query, with random idle cycles first, and hold it until accepted
  task automatic send_query(wwss_pkg::in_t q, bit typed, wwss_pkg::out_t result);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_data    <= q;
    row_typed  <= typed;
    row_result <= result;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every result is back and the pipe is quiet
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_wakes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [wwss_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[wwss_pkg::SLEEP_W-1:0];
    case (idx)
      wwss_pkg::CFG_FIRST_DAY:
        shadow_cfg.first_active_day    = value[wwss_pkg::DAY_W-1:0];
      wwss_pkg::CFG_LAST_DAY:
        shadow_cfg.last_active_day     = value[wwss_pkg::DAY_W-1:0];
      wwss_pkg::CFG_WIN_START:
        shadow_cfg.window_start_minute = value[wwss_pkg::MOD_W-1:0];
      wwss_pkg::CFG_WIN_END:
        shadow_cfg.window_end_minute   = value[wwss_pkg::MOD_W-1:0];
      wwss_pkg::CFG_UPDATE_INT:
        shadow_cfg.update_interval     = value[wwss_pkg::UPD_W-1:0];
      wwss_pkg::CFG_BACKOFF_INT:
        shadow_cfg.backoff_interval    = value[wwss_pkg::SLEEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_cfg(wwss_pkg::cfg_t c);
    drain_results();
    write_reg(wwss_pkg::CFG_FIRST_DAY, 32'(c.first_active_day));
    write_reg(wwss_pkg::CFG_LAST_DAY, 32'(c.last_active_day));
    write_reg(wwss_pkg::CFG_WIN_START, 32'(c.window_start_minute));
    write_reg(wwss_pkg::CFG_WIN_END, 32'(c.window_end_minute));
    write_reg(wwss_pkg::CFG_UPDATE_INT, 32'(c.update_interval));
    write_reg(wwss_pkg::CFG_BACKOFF_INT, 32'(c.backoff_interval));
  endtask

  // Check each result against the oldest expectation, then record the accepted query
  always @(posedge clk) begin
    wwss_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_wakes.size() == 0) begin
        $error("result with no transaction pending: sleep_seconds %0d, reason %0d",
               out_data.sleep_seconds, out_data.reason);
        error_count++;
      end else begin
        want = pending_wakes.pop_front();
        if (out_data.sleep_seconds !== want.sleep_seconds) begin
          $error("sleep_seconds: expected %0d, actual %0d",
                 want.sleep_seconds, out_data.sleep_seconds);
          error_count++;
        end
        if (out_data.reason !== want.reason) begin
          $error("reason: expected %0d, actual %0d", want.reason, out_data.reason);
          error_count++;
        end
      end
    end
    if (rst_n && start && !busy)
      pending_wakes.push_back(row_typed ? row_result : next_wake(in_data, shadow_cfg));
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    wwss_pkg::in_t  q;
    wwss_pkg::out_t typed_val;
    wwss_pkg::cfg_t phase_cfg;
    shadow_cfg = make_cfg(1, 5, 475, 1080, 300, 3600);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at reset settings
    foreach (directed_rows[i]) begin
      q.time_valid       = directed_rows[i].valid;
      q.weekday          = directed_rows[i].wday;
      q.hour_of_day      = directed_rows[i].hour;
      q.minute_of_hour   = directed_rows[i].minute;
      q.second_of_minute = directed_rows[i].second;
      typed_val.sleep_seconds = directed_rows[i].exp_sleep[wwss_pkg::SLEEP_W-1:0];
      typed_val.reason        = directed_rows[i].exp_reason;
      send_query(q, directed_rows[i].typed, typed_val);
    end

    // Random phases, each under its own settings and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_cfg = make_cfg(1, 5, 475, 1080, 300, 3600);
        1: phase_cfg = make_cfg(0, 6, 0, 1440, 1, 604800);
        2: phase_cfg = make_cfg(6, 0, 1439, 0, 86400, 1);
        3: phase_cfg = make_cfg(3, 3, 600, 660, 17, 604800);
        default: phase_cfg = rand_cfg();
      endcase
      load_cfg(phase_cfg);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 81;
        default: idle_pct = 37;
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++)
        send_query(rand_query(shadow_cfg), 1'b0, '0);
    end

    drain_results();
    if (error_count == 0 && pending_wakes.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_wakes.size() != 0)
        $error("%0d expected results never arrived", pending_wakes.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wwss_pkg.sv
sv/wwss_front.sv
sv/wwss_queue.sv
sv/wwss_back.sv
sv/wake_window_sleep_scheduler.sv
tb/wake_window_sleep_scheduler_tb.sv
